// ===== rtl/core/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// bole_pkg
// Command and status codes, and the control and status bundles that pass
// between the controller and the datapath of the ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam logic [2:0] CMD_FRONT      = 3'd0;
    localparam logic [2:0] CMD_END        = 3'd1;
    localparam logic [2:0] CMD_ORDERED    = 3'd2;
    localparam logic [2:0] CMD_DEL_FIRST  = 3'd3;
    localparam logic [2:0] CMD_DEL_BEFORE = 3'd4;
    localparam logic [2:0] CMD_DEL_AFTER  = 3'd5;
    localparam logic [2:0] CMD_DUMP       = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic load;
        logic eval;
        logic apply;
        logic dump_step;
    } bole_cmd_t;

    typedef struct packed {
        logic dump_go;
        logic dump_last;
    } bole_stat_t;

endpackage

// ===== rtl/core/bole_ctrl.sv =====
// ----------------------------------------------------------------------------
// bole_ctrl
// Sequencer of the ordered list engine: accept, evaluate, apply or stream
// the dump one beat per cycle.
// ----------------------------------------------------------------------------
module bole_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bole_pkg::bole_stat_t stat,
    output bole_pkg::bole_cmd_t  ctl
);
    import bole_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_APPLY = 4'b0100,
        S_DUMP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        ctl.load      = 1'b0;
        ctl.eval      = 1'b0;
        ctl.apply     = 1'b0;
        ctl.dump_step = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (stat.dump_go)
                begin
                    ctl.dump_step = 1'b1;
                    state_next    = stat.dump_last ? S_IDLE : S_DUMP;
                end
                else
                begin
                    ctl.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                ctl.dump_step = 1'b1;
                if (stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/bole_datapath.sv =====
// ----------------------------------------------------------------------------
// bole_datapath
// Chain of value cells with per-cell compare flags, a shift mask derived
// from the lowest set flag, a rotating dump and the result registers.
// ----------------------------------------------------------------------------
module bole_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bole_pkg::bole_cmd_t  ctl,
    output bole_pkg::bole_stat_t stat,
    input  logic [2:0]           command,
    input  logic signed [31:0]   value,
    input  logic [7:0]           position,
    output logic                 result_valid,
    output logic signed [31:0]   element,
    output logic [2:0]           status,
    output logic [4:0]           entry_total,
    output logic                 last
);
    import bole_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = 10;

    logic signed [31:0]  cell_reg [CAPACITY];
    logic signed [31:0]  cell_next [CAPACITY];
    logic [2:0]          cmd_reg;
    logic signed [31:0]  val_reg;
    logic [7:0]          pos_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       dump_left_reg;
    logic [CW-1:0]       dump_left_next;
    logic [CAPACITY-1:0] ge_reg;
    logic [CAPACITY-1:0] ge_next;
    logic [2:0]          st_reg;
    logic [2:0]          st_next;
    logic                mod_reg;
    logic                mod_next;
    logic                ins_reg;
    logic                ins_next;
    logic [PW-1:0]       cnt_w;
    logic [PW-1:0]       pos_w;
    logic [PW-1:0]       del_idx;
    logic [CAPACITY-1:0] low_run;
    logic [CAPACITY-1:0] mask;
    logic [CAPACITY-1:0] pick;
    logic                valid_reg;
    logic signed [31:0]  elem_reg;
    logic [2:0]          status_reg;
    logic [4:0]          total_reg;
    logic                last_reg;

    // evaluate: status and position flags
    always_comb
    begin
        cnt_w    = PW'(count_reg);
        pos_w    = PW'(pos_reg);
        st_next  = ST_OK;
        ins_next = 1'b0;
        del_idx  = '0;
        unique case (cmd_reg)
            CMD_FRONT, CMD_END, CMD_ORDERED:
            begin
                ins_next = 1'b1;
                if (cnt_w >= PW'(CAPACITY))
                begin
                    st_next = ST_FULL;
                end
            end
            CMD_DEL_FIRST:
            begin
                if (cnt_w == '0)
                begin
                    st_next = ST_EMPTY;
                end
            end
            CMD_DEL_BEFORE:
            begin
                del_idx = pos_w - PW'(2);
                if (cnt_w == '0 || pos_w <= PW'(1))
                begin
                    st_next = ST_INVALID;
                end
                else if (del_idx >= cnt_w)
                begin
                    st_next = ST_ABSENT;
                end
            end
            CMD_DEL_AFTER:
            begin
                del_idx = pos_w;
                if (cnt_w == '0 || pos_w == '0)
                begin
                    st_next = ST_INVALID;
                end
                else if (pos_w >= cnt_w)
                begin
                    st_next = ST_ABSENT;
                end
            end
            CMD_DUMP:
            begin
                if (cnt_w == '0)
                begin
                    st_next = ST_EMPTY;
                end
            end
            default:
            begin
                st_next = ST_INVALID;
            end
        endcase
        mod_next = (st_next == ST_OK) && (cmd_reg != CMD_DUMP);
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (ins_next)
            begin
                ge_next[k] = (PW'(k) >= cnt_w) || (cmd_reg == CMD_FRONT) ||
                             ((cmd_reg == CMD_ORDERED) && !(cell_reg[k] < val_reg));
            end
            else
            begin
                ge_next[k] = (PW'(k) == del_idx);
            end
        end
    end

    // apply: shift from the lowest set flag upwards
    always_comb
    begin
        low_run = ge_reg ^ (ge_reg - {{(CAPACITY-1){1'b0}}, 1'b1});
        mask    = ~(low_run >> 1);
        pick    = low_run & ge_reg;
        for (int k = 0; k < CAPACITY; k++)
        begin
            cell_next[k] = cell_reg[k];
            if (ctl.apply && mod_reg)
            begin
                if (ins_reg)
                begin
                    if (pick[k])
                    begin
                        cell_next[k] = val_reg;
                    end
                    else if (mask[k] && k > 0)
                    begin
                        cell_next[k] = cell_reg[(k > 0) ? k - 1 : 0];
                    end
                end
                else if (mask[k] && k < CAPACITY - 1)
                begin
                    cell_next[k] = cell_reg[(k < CAPACITY - 1) ? k + 1 : k];
                end
            end
            else if (ctl.dump_step)
            begin
                if (PW'(k) == cnt_w - PW'(1))
                begin
                    cell_next[k] = cell_reg[0];
                end
                else if (k < CAPACITY - 1)
                begin
                    cell_next[k] = cell_reg[(k < CAPACITY - 1) ? k + 1 : k];
                end
            end
        end

        count_next = count_reg;
        if (ctl.apply && mod_reg)
        begin
            count_next = ins_reg ? count_reg + CW'(1) : count_reg - CW'(1);
        end

        dump_left_next = dump_left_reg;
        if (ctl.eval)
        begin
            dump_left_next = count_reg;
        end
        else if (ctl.dump_step)
        begin
            dump_left_next = dump_left_reg - CW'(1);
        end
    end

    assign stat.dump_go   = (cmd_reg == CMD_DUMP) && (st_reg == ST_OK);
    assign stat.dump_last = (dump_left_reg == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dump_left_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            valid_reg     <= ctl.apply || ctl.dump_step;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            cell_reg[k] <= cell_next[k];
        end
        if (ctl.load)
        begin
            cmd_reg <= command;
            val_reg <= value;
            pos_reg <= position;
        end
        if (ctl.eval)
        begin
            ge_reg  <= ge_next;
            st_reg  <= st_next;
            mod_reg <= mod_next;
            ins_reg <= ins_next;
        end
        if (ctl.apply || ctl.dump_step)
        begin
            elem_reg   <= ctl.dump_step ? cell_reg[0] : 32'sd0;
            status_reg <= ctl.dump_step ? ST_OK : st_reg;
            total_reg  <= 5'(count_next);
            last_reg   <= ctl.apply || (dump_left_reg == CW'(1));
        end
    end

    assign result_valid = valid_reg;
    assign element      = elem_reg;
    assign status       = status_reg;
    assign entry_total  = total_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/core/bounded_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command but a
// dump of a non-empty list returns one beat, registered after its evaluate
// and apply steps, and the next command can be taken in the cycle that beat
// is shown. A dump of n elements returns n beats on consecutive cycles. In
// the evaluate step every cell sets its flag in parallel, comparing against
// the new value for an ordered insert; in the apply step the whole chain
// shifts; a dump rotates the chain one cell a cycle. Each beat is on the
// result ports for one cycle only, marked by result_valid; the receiver
// cannot stall it, so it must take every beat.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         command,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               result_valid,
    output logic signed [31:0] element,
    output logic [2:0]         status,
    output logic [4:0]         entry_total,
    output logic               last
);
    import bole_pkg::*;

    bole_cmd_t  ctl;
    bole_stat_t stat;

    bole_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    bole_datapath #(.CAPACITY(CAPACITY)) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .command      (command),
        .value        (value),
        .position     (position),
        .result_valid (result_valid),
        .element      (element),
        .status       (status),
        .entry_total  (entry_total),
        .last         (last)
    );

endmodule
